FILE: rtl/heap_cache_replacement_policy_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the heap cache replacement engine
// Immediate-implication and next-cycle-implication forms; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef HEAP_CACHE_REPLACEMENT_POLICY_TOP_MACROS_SVH
`define HEAP_CACHE_REPLACEMENT_POLICY_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define HCRP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hcrp assertion failed");
`define HCRP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hcrp assertion failed");
`else
`define HCRP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define HCRP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/hcrp_pkg.sv
// ----------------------------------------------------------------------------
// hcrp_pkg
// Types, codes and the policy key function of the cache replacement engine.
// ----------------------------------------------------------------------------
package hcrp_pkg;

	localparam int ITEM_W     = 10;
	localparam int CNT_W      = 32;
	localparam int LAST_W     = 33;
	localparam int KEY_W      = 34;
	localparam int CAP_W      = 7;
	localparam int POL_W      = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;

	localparam logic OP_TALLY  = 1'b0;
	localparam logic OP_ACCESS = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_POLICY   = 1'b1;

	localparam logic [POL_W-1:0] POL_MRU = 2'd0;
	localparam logic [POL_W-1:0] POL_LRU = 2'd1;

	typedef struct packed {
		logic              operation;
		logic [ITEM_W-1:0] item_id;
	} req_t;

	typedef struct packed {
		logic              hit;
		logic              evicted_valid;
		logic [ITEM_W-1:0] evicted_item;
		logic [CNT_W-1:0]  miss_count;
	} rsp_t;

	// per-item bookkeeping; last is two's complement, -1 = never used
	typedef struct packed {
		logic [LAST_W-1:0] last;
		logic [CNT_W-1:0]  tally;
	} item_dat_t;

	// heap slot: item plus a copy of its key sources
	typedef struct packed {
		logic [ITEM_W-1:0] item;
		item_dat_t         dat;
	} heap_ent_t;

	typedef enum logic [4:0] {
		DP_NOP,
		DP_CLEAR,
		DP_LOAD,
		DP_TALLY,
		DP_HIT,
		DP_MISS,
		DP_EVICT,
		DP_EVLAST,
		DP_INSERT,
		DP_STAMP,
		DP_UP_RD,
		DP_UP_CMP,
		DP_PLACE,
		DP_DN_RD1,
		DP_DN_RD2,
		DP_DN_SEL,
		DP_OUT
	} dp_cmd_t;

	typedef struct packed {
		logic in_range;
		logic is_tally;
		logic resident;
		logic full;
		logic cnt_zero;
		logic pos_gt1;
		logic up_move;
		logic dn_has_l;
		logic dn_move;
		logic out_free;
		logic clr_last;
	} dp_stat_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ITEM,
		ST_EVICT,
		ST_EVLAST,
		ST_INSERT,
		ST_STAMP,
		ST_UP_RD,
		ST_UP_CMP,
		ST_DN_RD1,
		ST_DN_RD2,
		ST_DN_SEL,
		ST_OUT
	} ctrl_state_t;

	typedef enum logic [1:0] {
		PH_EVDOWN,
		PH_INSUP,
		PH_RSUP,
		PH_RSDOWN
	} phase_t;

	function automatic logic signed [KEY_W-1:0] key_of(input item_dat_t d,
		input logic [POL_W-1:0] pol);
		logic signed [KEY_W-1:0] l;
		logic signed [KEY_W-1:0] k;
		l = $signed({d.last[LAST_W-1], d.last});
		unique case (pol)
			POL_MRU: k = l;
			POL_LRU: k = -l;
			default: k = -$signed({2'b00, d.tally});
		endcase
		return k;
	endfunction

endpackage

FILE: rtl/hcrp_ram.sv
// ----------------------------------------------------------------------------
// hcrp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hcrp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/hcrp_ctrl.sv
// ----------------------------------------------------------------------------
// hcrp_ctrl
// Sequencer: clearing pass, item decode, eviction, insert and heap sifts.
// ----------------------------------------------------------------------------
module hcrp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  hcrp_pkg::dp_stat_t stat,
	output hcrp_pkg::dp_cmd_t  cmd
);

	import hcrp_pkg::*;

	ctrl_state_t state_q, state_d;
	phase_t      phase_q, phase_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			phase_q <= PH_RSUP;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		phase_d   = phase_q;
		cmd       = DP_NOP;
		req_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd = DP_CLEAR;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd     = DP_LOAD;
					state_d = ST_ITEM;
				end
			end
			ST_ITEM: begin
				priority if (!stat.in_range) begin
					state_d = ST_OUT;
				end else if (stat.is_tally) begin
					cmd = DP_TALLY;
					if (stat.resident) begin
						phase_d = PH_RSUP;
						state_d = ST_UP_RD;
					end else begin
						state_d = ST_OUT;
					end
				end else if (stat.resident) begin
					cmd     = DP_HIT;
					phase_d = PH_RSUP;
					state_d = ST_UP_RD;
				end else begin
					cmd     = DP_MISS;
					state_d = stat.full ? ST_EVICT : ST_INSERT;
				end
			end
			ST_EVICT: begin
				cmd     = DP_EVICT;
				state_d = ST_EVLAST;
			end
			ST_EVLAST: begin
				cmd = DP_EVLAST;
				if (stat.cnt_zero) begin
					state_d = ST_INSERT;
				end else begin
					phase_d = PH_EVDOWN;
					state_d = ST_DN_RD1;
				end
			end
			ST_INSERT: begin
				cmd     = DP_INSERT;
				phase_d = PH_INSUP;
				state_d = ST_UP_RD;
			end
			ST_STAMP: begin
				cmd     = DP_STAMP;
				phase_d = PH_RSUP;
				state_d = ST_UP_RD;
			end
			ST_UP_RD: begin
				if (stat.pos_gt1) begin
					cmd     = DP_UP_RD;
					state_d = ST_UP_CMP;
				end else begin
					cmd = DP_PLACE;
					if (phase_q == PH_INSUP) begin
						state_d = ST_STAMP;
					end else begin
						phase_d = PH_RSDOWN;
						state_d = ST_DN_RD1;
					end
				end
			end
			ST_UP_CMP: begin
				cmd = DP_UP_CMP;
				if (stat.up_move) begin
					state_d = ST_UP_RD;
				end else if (phase_q == PH_INSUP) begin
					state_d = ST_STAMP;
				end else begin
					phase_d = PH_RSDOWN;
					state_d = ST_DN_RD1;
				end
			end
			ST_DN_RD1: begin
				if (stat.dn_has_l) begin
					cmd     = DP_DN_RD1;
					state_d = ST_DN_RD2;
				end else begin
					cmd     = DP_PLACE;
					state_d = (phase_q == PH_EVDOWN) ? ST_INSERT : ST_OUT;
				end
			end
			ST_DN_RD2: begin
				cmd     = DP_DN_RD2;
				state_d = ST_DN_SEL;
			end
			ST_DN_SEL: begin
				cmd = DP_DN_SEL;
				if (stat.dn_move) begin
					state_d = ST_DN_RD1;
				end else begin
					state_d = (phase_q == PH_EVDOWN) ? ST_INSERT : ST_OUT;
				end
			end
			ST_OUT: begin
				if (stat.out_free) begin
					cmd     = DP_OUT;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/hcrp_dp.sv
// ----------------------------------------------------------------------------
// hcrp_dp
// Datapath: item and heap memories, held entry, counters, result register.
// ----------------------------------------------------------------------------
`include "heap_cache_replacement_policy_top_macros.svh"

module hcrp_dp #(
	parameter int NUM_ITEMS   = 1024,
	parameter int CACHE_DEPTH = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  hcrp_pkg::dp_cmd_t                  cmd,
	output hcrp_pkg::dp_stat_t                 stat,
	input  hcrp_pkg::req_t                     req,
	output hcrp_pkg::rsp_t                     rsp,
	output logic                               rsp_valid,
	input  logic                               rsp_ready,
	input  logic                               cfg_we,
	input  logic [hcrp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [hcrp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

	import hcrp_pkg::*;

	localparam int IAW = $clog2(NUM_ITEMS);
	localparam int SW  = $clog2(CACHE_DEPTH + 1);
	localparam int AW  = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
	localparam int HW  = $bits(heap_ent_t);
	localparam int DW  = $bits(item_dat_t);

	// control state
	logic [SW-1:0]    cnt_q;
	logic [CNT_W-1:0] time_q;
	logic [CNT_W-1:0] miss_q;
	logic [CAP_W-1:0] cap_q;
	logic [POL_W-1:0] pol_q;
	logic [IAW-1:0]   clr_q;
	logic             rsp_valid_q;

	// payload
	logic              op_q;
	logic [ITEM_W-1:0] id_q;
	heap_ent_t         cur_q, new_q, cha_q;
	logic [SW-1:0]     pos_q;
	logic              hasr_q;
	logic              hit_q, evv_q;
	logic [ITEM_W-1:0] evi_q;
	rsp_t              rsp_q;

	// memory ports
	logic            heap_we, heap_re;
	logic [AW-1:0]   heap_waddr, heap_raddr;
	heap_ent_t       heap_wdata, heap_rd;
	logic            slot_we, item_re;
	logic [IAW-1:0]  slot_waddr, item_raddr;
	logic [SW-1:0]   slot_wdata, slot_rd;
	logic            dat_we;
	logic [IAW-1:0]  dat_waddr;
	item_dat_t       dat_wdata, dat_rd;

	logic            pl_en;
	logic [SW-1:0]   pl_pos;
	heap_ent_t       pl_ent;

	logic [SW:0]     pos2, pos2p1, cnt_w, ch_pos;
	logic signed [KEY_W-1:0] k_cur, k_rd, k_a, k_ch;
	logic            sel_b;
	heap_ent_t       chosen;
	logic [CAP_W-1:0] cap1;
	logic [IAW-1:0]  id_addr;
	logic [CNT_W-1:0] tinc, time_inc, miss_inc;

	hcrp_ram #(.WIDTH(HW), .DEPTH(CACHE_DEPTH)) u_heap_ram (
		.clk   (clk),
		.we    (heap_we),
		.waddr (heap_waddr),
		.wdata (heap_wdata),
		.re    (heap_re),
		.raddr (heap_raddr),
		.rdata (heap_rd)
	);

	hcrp_ram #(.WIDTH(SW), .DEPTH(NUM_ITEMS)) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.re    (item_re),
		.raddr (item_raddr),
		.rdata (slot_rd)
	);

	hcrp_ram #(.WIDTH(DW), .DEPTH(NUM_ITEMS)) u_dat_ram (
		.clk   (clk),
		.we    (dat_we),
		.waddr (dat_waddr),
		.wdata (dat_wdata),
		.re    (item_re),
		.raddr (item_raddr),
		.rdata (dat_rd)
	);

	assign id_addr  = IAW'(id_q);
	assign pos2     = {pos_q, 1'b0};
	assign pos2p1   = {pos_q, 1'b1};
	assign cnt_w    = {1'b0, cnt_q};
	assign k_cur    = key_of(cur_q.dat, pol_q);
	assign k_rd     = key_of(heap_rd.dat, pol_q);
	assign k_a      = key_of(cha_q.dat, pol_q);
	assign sel_b    = hasr_q && (k_a < k_rd);
	assign chosen   = sel_b ? heap_rd : cha_q;
	assign k_ch     = sel_b ? k_rd : k_a;
	assign ch_pos   = sel_b ? pos2p1 : pos2;
	assign cap1     = (cap_q == '0) ? CAP_W'(1) : cap_q;
	assign tinc     = (dat_rd.tally == '1) ? dat_rd.tally : dat_rd.tally + 1'b1;
	assign time_inc = (time_q == '1) ? time_q : time_q + 1'b1;
	assign miss_inc = (miss_q == '1) ? miss_q : miss_q + 1'b1;

	always_comb begin
		stat.in_range = 32'(id_q) < 32'(NUM_ITEMS);
		stat.is_tally = op_q == OP_TALLY;
		stat.resident = slot_rd != '0;
		stat.full     = (cnt_q != '0) && ((32'(cnt_q) >= 32'(cap1)) ||
			(32'(cnt_q) >= 32'(CACHE_DEPTH)));
		stat.cnt_zero = cnt_q == '0;
		stat.pos_gt1  = pos_q > SW'(1);
		stat.up_move  = k_cur > k_rd;
		stat.dn_has_l = pos2 <= cnt_w;
		stat.dn_move  = k_ch > k_cur;
		stat.out_free = !rsp_valid_q || rsp_ready;
		stat.clr_last = clr_q == IAW'(NUM_ITEMS - 1);
	end

	// memory port steering
	always_comb begin
		heap_re    = 1'b0;
		heap_raddr = '0;
		item_re    = 1'b0;
		item_raddr = IAW'(req.item_id);
		slot_we    = 1'b0;
		slot_waddr = clr_q;
		slot_wdata = '0;
		dat_we     = 1'b0;
		dat_waddr  = id_addr;
		dat_wdata  = '{last: '1, tally: '0};
		pl_en      = 1'b0;
		pl_pos     = pos_q;
		pl_ent     = cur_q;
		unique case (cmd)
			DP_CLEAR: begin
				slot_we   = 1'b1;
				dat_we    = 1'b1;
				dat_waddr = clr_q;
			end
			DP_LOAD: item_re = 1'b1;
			DP_TALLY: begin
				dat_we    = 1'b1;
				dat_wdata = '{last: dat_rd.last, tally: tinc};
			end
			DP_HIT: begin
				dat_we    = 1'b1;
				dat_wdata = '{last: {1'b0, time_q}, tally: dat_rd.tally};
			end
			DP_MISS: begin
				heap_re    = 1'b1;
				heap_raddr = '0;
			end
			DP_EVICT: begin
				heap_re    = 1'b1;
				heap_raddr = AW'(cnt_q - 1'b1);
				slot_we    = 1'b1;
				slot_waddr = IAW'(heap_rd.item);
			end
			DP_STAMP: begin
				dat_we    = 1'b1;
				dat_wdata = '{last: {1'b0, time_q}, tally: cur_q.dat.tally};
			end
			DP_UP_RD: begin
				heap_re    = 1'b1;
				heap_raddr = AW'((pos_q >> 1) - 1'b1);
			end
			DP_UP_CMP: begin
				pl_en = 1'b1;
				if (stat.up_move) begin
					pl_ent = heap_rd;
				end
			end
			DP_PLACE: pl_en = 1'b1;
			DP_DN_RD1: begin
				heap_re    = 1'b1;
				heap_raddr = AW'(pos2 - 1'b1);
			end
			DP_DN_RD2: begin
				heap_re    = pos2p1 <= cnt_w;
				heap_raddr = AW'(pos2);
			end
			DP_DN_SEL: begin
				pl_en = 1'b1;
				if (stat.dn_move) begin
					pl_ent = chosen;
				end
			end
			default: begin
			end
		endcase
		// a heap placement also records the slot of the placed item
		if (pl_en) begin
			slot_we    = 1'b1;
			slot_waddr = IAW'(pl_ent.item);
			slot_wdata = pl_pos;
		end
	end

	assign heap_we    = pl_en;
	assign heap_waddr = AW'(pl_pos - 1'b1);
	assign heap_wdata = pl_ent;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			time_q      <= '0;
			miss_q      <= '0;
			cap_q       <= CAP_W'(64);
			pol_q       <= POL_MRU;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_CAPACITY: cap_q <= cfg_wdata;
					CFG_POLICY:   pol_q <= cfg_wdata[POL_W-1:0];
					default: begin
					end
				endcase
			end
			if (cmd == DP_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd == DP_EVICT) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd == DP_INSERT) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd == DP_HIT || cmd == DP_STAMP) begin
				time_q <= time_inc;
			end
			if (cmd == DP_STAMP) begin
				miss_q <= miss_inc;
			end
			if (cmd == DP_OUT) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd)
			DP_LOAD: begin
				op_q  <= req.operation;
				id_q  <= req.item_id;
				hit_q <= 1'b0;
				evv_q <= 1'b0;
				evi_q <= '0;
			end
			DP_TALLY: begin
				cur_q <= '{item: id_q, dat: '{last: dat_rd.last, tally: tinc}};
				pos_q <= slot_rd;
			end
			DP_HIT: begin
				cur_q <= '{item: id_q, dat: '{last: {1'b0, time_q}, tally: dat_rd.tally}};
				pos_q <= slot_rd;
				hit_q <= 1'b1;
			end
			DP_MISS: new_q <= '{item: id_q, dat: dat_rd};
			DP_EVICT: begin
				evv_q <= 1'b1;
				evi_q <= heap_rd.item;
			end
			DP_EVLAST: begin
				cur_q <= heap_rd;
				pos_q <= SW'(1);
			end
			DP_INSERT: begin
				cur_q <= new_q;
				pos_q <= cnt_q + 1'b1;
			end
			DP_STAMP: cur_q.dat.last <= {1'b0, time_q};
			DP_UP_CMP: begin
				if (stat.up_move) begin
					pos_q <= pos_q >> 1;
				end
			end
			DP_DN_RD2: begin
				cha_q  <= heap_rd;
				hasr_q <= pos2p1 <= cnt_w;
			end
			DP_DN_SEL: begin
				if (stat.dn_move) begin
					pos_q <= SW'(ch_pos);
				end
			end
			DP_OUT: begin
				rsp_q <= '{hit: hit_q, evicted_valid: evv_q, evicted_item: evi_q,
					miss_count: miss_q};
			end
			default: begin
			end
		endcase
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

	`HCRP_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, 32'(cnt_q) <= 32'(CACHE_DEPTH))
	`HCRP_ASSERT_IMP(a_ins_room, clk, arst_n, cmd == DP_INSERT, 32'(cnt_q) < 32'(CACHE_DEPTH))
	`HCRP_ASSERT_IMP(a_ev_access, clk, arst_n, evv_q && cmd == DP_OUT, op_q == OP_ACCESS)

endmodule

FILE: rtl/heap_cache_replacement_policy_top.sv
// ----------------------------------------------------------------------------
// heap_cache_replacement_policy_top
// Cache replacement engine: residency, eviction from a max-heap on policy key.
//
//   channel   signals                          transaction when
//   req       req_valid/req_ready/req          req_valid && req_ready
//   rsp       rsp_valid/rsp_ready/rsp          rsp_valid && rsp_ready
//   cfg       cfg_we/cfg_index/cfg_wdata       cfg_we (0 capacity, 1 policy)
//
// One request at a time. Sifts run over the heap memory, level by level.
// After reset a clearing pass initializes the per-item memories; req_ready
// stays low meanwhile, configuration writes still land.
// A finished result waits in the output register; the next request is taken
// while it waits, and its own result is held back until the register frees.
// ----------------------------------------------------------------------------
module heap_cache_replacement_policy_top #(
	parameter int NUM_ITEMS   = 1024,
	parameter int CACHE_DEPTH = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_ready,
	input  hcrp_pkg::req_t                  req,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output hcrp_pkg::rsp_t                  rsp,
	input  logic                            cfg_we,
	input  logic [hcrp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hcrp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	import hcrp_pkg::*;

	// command/status between sequencer and datapath
	dp_cmd_t  cmd;
	dp_stat_t stat;

	hcrp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// heap, per-item memories, counters and the result register
	hcrp_dp #(
		.NUM_ITEMS   (NUM_ITEMS),
		.CACHE_DEPTH (CACHE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.req       (req),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

endmodule
